// ----- sv/assert_macros.svh -----
// assertion macros used by the port-level checker in tmse_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- sv/tmse_pkg.sv -----
// types, constants and codes of the turing machine step engine
// no dependencies
package tmse_pkg;
    localparam int TAPE_CELLS = 128;
    localparam int MAX_RULES  = 128;
    localparam int MAX_FINALS = 128;
    localparam int TIW = $clog2(TAPE_CELLS);
    localparam int RIW = $clog2(MAX_RULES);
    localparam int RCW = $clog2(MAX_RULES + 1);
    localparam int FIW = (MAX_FINALS > 1) ? $clog2(MAX_FINALS) : 1;
    localparam int FCW = $clog2(MAX_FINALS + 1);
    localparam logic [7:0] BLANK_SYMBOL = 8'd66;

    localparam logic [2:0] CMD_CLEAR     = 3'd0;
    localparam logic [2:0] CMD_ADD_RULE  = 3'd1;
    localparam logic [2:0] CMD_ADD_FINAL = 3'd2;
    localparam logic [2:0] CMD_WRITE     = 3'd3;
    localparam logic [2:0] CMD_STEP      = 3'd4;
    localparam logic [2:0] CMD_READ      = 3'd5;

    localparam logic [1:0] MOVE_RIGHT = 2'd1;
    localparam logic [1:0] MOVE_LEFT  = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HALT  = 2'd1;
    localparam logic [1:0] ST_FAULT = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0] cmd;
        logic [7:0] rule_from_state;
        logic [7:0] rule_read_symbol;
        logic [7:0] rule_next_state;
        logic [7:0] rule_write_symbol;
        logic [1:0] rule_move;
        logic [7:0] accept_state;
        logic [6:0] cell_index;
        logic [7:0] cell_symbol;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] machine_state;
        logic [6:0] head_position;
        logic [7:0] symbol_out;
        logic       accepted;
        logic       has_final_states;
    } t_out_item;

    typedef struct packed {
        logic [7:0] from_state;
        logic [7:0] read_symbol;
        logic [7:0] next_state;
        logic [7:0] write_symbol;
        logic [1:0] move;
    } t_rule;

    typedef struct packed {
        logic latch;
        logic exec;
        logic tape_rd;
        logic tape_cap;
        logic rscan_start;
        logic rscan;
        logic fscan_start;
        logic fscan;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic [2:0] cmd;
        logic       faulted;
        logic       rule_hit;
        logic       rule_end;
        logic       final_hit;
        logic       final_end;
        logic       out_free;
    } t_sts;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_HRD, S_HCAP, S_RSCAN, S_FSTART, S_FSCAN, S_TRD, S_TCAP, S_OUT
    } t_state;
endpackage

// ----- sv/tmse_ctrl.sv -----
// controller state machine sequencing one item through the datapath
// depends on tmse_pkg
module tmse_ctrl import tmse_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_ctl o_ctl
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_ctl.latch = 1'b1;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                o_ctl.exec = 1'b1;
                if (i_sts.cmd == CMD_STEP && !i_sts.faulted) begin
                    n_state = S_HRD;
                end else begin
                    n_state = S_FSTART;
                end
            end
            S_HRD: begin
                o_ctl.tape_rd = 1'b1;
                n_state = S_HCAP;
            end
            S_HCAP: begin
                o_ctl.tape_cap    = 1'b1;
                o_ctl.rscan_start = 1'b1;
                n_state = S_RSCAN;
            end
            S_RSCAN: begin
                o_ctl.rscan = 1'b1;
                if (i_sts.rule_hit || i_sts.rule_end) begin
                    n_state = S_FSTART;
                end
            end
            S_FSTART: begin
                o_ctl.fscan_start = 1'b1;
                n_state = S_FSCAN;
            end
            S_FSCAN: begin
                o_ctl.fscan = 1'b1;
                if (i_sts.final_hit || i_sts.final_end) begin
                    n_state = S_TRD;
                end
            end
            S_TRD: begin
                o_ctl.tape_rd = 1'b1;
                n_state = S_TCAP;
            end
            S_TCAP: begin
                o_ctl.tape_cap = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

// ----- sv/tmse_dp.sv -----
// datapath: tape, rule table and final list memories, machine registers, result register
// depends on tmse_pkg
module tmse_dp import tmse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_item  i_in_data,
    input  t_ctl      i_ctl,
    output t_sts      o_sts,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    t_in_item            r_item;
    logic [7:0]          r_tape [TAPE_CELLS];
    logic [TAPE_CELLS-1:0] r_tvalid;
    logic [7:0]          r_tape_q;
    logic                r_tv_q;
    t_rule               r_rules [MAX_RULES];
    t_rule               r_rule_q;
    logic [7:0]          r_finals [MAX_FINALS];
    logic [7:0]          r_final_q;
    logic [RCW-1:0]      r_rule_cnt;
    logic [FCW-1:0]      r_fin_cnt;
    logic [RCW-1:0]      r_ridx;
    logic                r_rcmp_v;
    logic [FCW-1:0]      r_fidx;
    logic                r_fcmp_v;
    logic [7:0]          r_cur;
    logic [TIW-1:0]      r_head;
    logic                r_fault;
    logic [1:0]          r_status;
    logic [7:0]          r_sym;
    logic                r_acc;
    logic                r_ov;
    t_out_item           r_out;

    logic           rissue, fissue, rhit, fhit, apply;
    logic           t_we;
    logic [TIW-1:0] t_wa, t_ra;
    logic [7:0]     t_wd;
    logic           rule_we, fin_we;

    assign rissue = r_ridx < r_rule_cnt;
    assign fissue = r_fidx < r_fin_cnt;
    assign rhit   = r_rcmp_v && r_rule_q.from_state == r_cur && r_rule_q.read_symbol == r_sym;
    assign fhit   = r_fcmp_v && r_final_q == r_cur;
    assign apply  = i_ctl.rscan && rhit;

    assign rule_we = i_ctl.exec && r_item.cmd == CMD_ADD_RULE && r_rule_cnt != RCW'(MAX_RULES);
    assign fin_we  = i_ctl.exec && r_item.cmd == CMD_ADD_FINAL && r_fin_cnt != FCW'(MAX_FINALS);

    always_comb begin
        t_we = 1'b0;
        t_wa = r_head;
        t_wd = r_rule_q.write_symbol;
        if (apply) begin
            t_we = 1'b1;
        end else if (i_ctl.exec && r_item.cmd == CMD_WRITE) begin
            t_we = 1'b1;
            t_wa = r_item.cell_index;
            t_wd = r_item.cell_symbol;
        end
        t_ra = (r_item.cmd == CMD_READ) ? r_item.cell_index : r_head;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_item <= i_in_data;
        end
        if (t_we) begin
            r_tape[t_wa] <= t_wd;
        end
        if (i_ctl.tape_rd) begin
            r_tape_q <= r_tape[t_ra];
            r_tv_q   <= r_tvalid[t_ra];
        end
        if (i_ctl.tape_cap) begin
            r_sym <= r_tv_q ? r_tape_q : BLANK_SYMBOL;
        end
        if (rule_we) begin
            r_rules[r_rule_cnt[RIW-1:0]] <= '{r_item.rule_from_state, r_item.rule_read_symbol,
                r_item.rule_next_state, r_item.rule_write_symbol, r_item.rule_move};
        end
        if (i_ctl.rscan && rissue) begin
            r_rule_q <= r_rules[r_ridx[RIW-1:0]];
        end
        if (fin_we) begin
            r_finals[r_fin_cnt[FIW-1:0]] <= r_item.accept_state;
        end
        if (i_ctl.fscan && fissue) begin
            r_final_q <= r_finals[r_fidx[FIW-1:0]];
        end
        if (i_ctl.out_load) begin
            r_out <= '{r_status, r_cur, r_head, r_sym, r_acc, r_fin_cnt != '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid   <= '0;
            r_rule_cnt <= '0;
            r_fin_cnt  <= '0;
            r_cur      <= '0;
            r_head     <= '0;
            r_fault    <= 1'b0;
            r_status   <= ST_OK;
            r_ridx     <= '0;
            r_rcmp_v   <= 1'b0;
            r_fidx     <= '0;
            r_fcmp_v   <= 1'b0;
            r_acc      <= 1'b0;
            r_ov       <= 1'b0;
        end else begin
            if (t_we) begin
                r_tvalid[t_wa] <= 1'b1;
            end
            if (i_ctl.exec) begin
                r_status <= ST_OK;
                case (r_item.cmd)
                    CMD_CLEAR: begin
                        r_tvalid   <= '0;
                        r_rule_cnt <= '0;
                        r_fin_cnt  <= '0;
                        r_cur      <= '0;
                        r_head     <= '0;
                        r_fault    <= 1'b0;
                    end
                    CMD_ADD_RULE: begin
                        if (rule_we) begin
                            r_rule_cnt <= r_rule_cnt + RCW'(1);
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    CMD_ADD_FINAL: begin
                        if (fin_we) begin
                            r_fin_cnt <= r_fin_cnt + FCW'(1);
                        end else begin
                            r_status <= ST_FULL;
                        end
                    end
                    CMD_STEP: r_status <= r_fault ? ST_FAULT : ST_HALT;
                    default: ;
                endcase
            end
            if (i_ctl.rscan_start) begin
                r_ridx   <= '0;
                r_rcmp_v <= 1'b0;
            end else if (i_ctl.rscan) begin
                r_rcmp_v <= rissue;
                if (rissue) begin
                    r_ridx <= r_ridx + RCW'(1);
                end
            end
            if (apply) begin
                r_cur    <= r_rule_q.next_state;
                r_status <= ST_OK;
                if (r_rule_q.move == MOVE_RIGHT) begin
                    if (r_head == TIW'(TAPE_CELLS - 1)) begin
                        r_fault  <= 1'b1;
                        r_status <= ST_FAULT;
                    end else begin
                        r_head <= r_head + TIW'(1);
                    end
                end else if (r_rule_q.move == MOVE_LEFT) begin
                    if (r_head == '0) begin
                        r_fault  <= 1'b1;
                        r_status <= ST_FAULT;
                    end else begin
                        r_head <= r_head - TIW'(1);
                    end
                end
            end
            if (i_ctl.fscan_start) begin
                r_fidx   <= '0;
                r_fcmp_v <= 1'b0;
                r_acc    <= 1'b0;
            end else if (i_ctl.fscan) begin
                r_fcmp_v <= fissue;
                if (fissue) begin
                    r_fidx <= r_fidx + FCW'(1);
                end
                if (fhit) begin
                    r_acc <= 1'b1;
                end
            end
            if (i_ctl.out_load) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    assign o_sts.cmd       = r_item.cmd;
    assign o_sts.faulted   = r_fault;
    assign o_sts.rule_hit  = rhit;
    assign o_sts.rule_end  = !r_rcmp_v && !rissue;
    assign o_sts.final_hit = fhit;
    assign o_sts.final_end = !r_fcmp_v && !fissue;
    assign o_sts.out_free  = !r_ov || i_out_ready;
    assign o_out_valid     = r_ov;
    assign o_out_data      = r_out;
endmodule

// ----- sv/turing_machine_step_engine.sv -----
// top level of the turing machine step engine: controller plus datapath
// depends on tmse_pkg, tmse_ctrl, tmse_dp
//
// channel  | valid       | ready       | payload
// input    | i_in_valid  | o_in_ready  | i_in_data  (t_in_item)
// output   | o_out_valid | i_out_ready | o_out_data (t_out_item)
//
// one item at a time; ready only while idle
// a non-step item scans only the final list before the next ready
// a step scans the rule table (not once faulted), then the final list; the rule table
// and final list memories give one read per cycle
// reset clears tape valid bits, counts and machine registers at once
// a stalled output holds the engine in its output state
module turing_machine_step_engine import tmse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);
    t_ctl ctl;
    t_sts sts;

    tmse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_ctl      (ctl)
    );

    tmse_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_ctl       (ctl),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

// ----- sv/tmse_checker.sv -----
// port-level checker for the turing machine step engine, bound to the top level
// depends on tmse_pkg and assert_macros.svh
`include "assert_macros.svh"
module tmse_checker import tmse_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);
    `ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))
    `ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_IMP(a_accept_needs_final, i_clk, i_rst_n, o_out_valid && o_out_data.accepted, o_out_data.has_final_states)
endmodule

bind turing_machine_step_engine tmse_checker u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ----- tb/tb_checker.sv -----
`timescale 1ns / 1ps
// checker for the turing machine step engine: watches both channels, predicts each result
// depends on tmse_pkg; hands its mismatch count to tb_top
module tb_checker import tmse_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_errors,
    output int        o_pending,
    output int        o_results,
    output int        o_steps_ok,
    output int        o_faults
);
    logic [7:0] tape[TAPE_CELLS];
    t_rule      rules[MAX_RULES];
    logic [7:0] finals[MAX_FINALS];
    int         n_rules;
    int         n_finals;
    logic [7:0] mstate;
    int         head;
    logic       faulted;
    t_out_item  expected_results[$];

    assign o_pending = expected_results.size();

    function automatic void clear_machine();
        for (int i = 0; i < TAPE_CELLS; i++) tape[i] = BLANK_SYMBOL;
        n_rules = 0;
        n_finals = 0;
        mstate = '0;
        head = 0;
        faulted = 1'b0;
    endfunction

    function automatic t_out_item machine_step(t_in_item it);
        t_out_item r;
        logic      rd;
        logic [7:0] rv;
        rd = 1'b0;
        rv = '0;
        r = '0;
        r.status = ST_OK;
        case (it.cmd)
            CMD_CLEAR: clear_machine();
            CMD_ADD_RULE: begin
                if (n_rules >= MAX_RULES) begin
                    r.status = ST_FULL;
                end else begin
                    rules[n_rules] = '{it.rule_from_state, it.rule_read_symbol,
                                       it.rule_next_state, it.rule_write_symbol, it.rule_move};
                    n_rules++;
                end
            end
            CMD_ADD_FINAL: begin
                if (n_finals >= MAX_FINALS) begin
                    r.status = ST_FULL;
                end else begin
                    finals[n_finals] = it.accept_state;
                    n_finals++;
                end
            end
            CMD_WRITE: if (it.cell_index < TAPE_CELLS) tape[it.cell_index] = it.cell_symbol;
            CMD_STEP: begin
                if (faulted) begin
                    r.status = ST_FAULT;
                end else begin
                    r.status = ST_HALT;
                    for (int i = 0; i < n_rules; i++) begin
                        if (rules[i].from_state == mstate && rules[i].read_symbol == tape[head]) begin
                            tape[head] = rules[i].write_symbol;
                            mstate = rules[i].next_state;
                            r.status = ST_OK;
                            if (rules[i].move == MOVE_RIGHT) begin
                                if (head + 1 >= TAPE_CELLS) begin
                                    faulted = 1'b1;
                                    r.status = ST_FAULT;
                                end else begin
                                    head++;
                                end
                            end else if (rules[i].move == MOVE_LEFT) begin
                                if (head == 0) begin
                                    faulted = 1'b1;
                                    r.status = ST_FAULT;
                                end else begin
                                    head--;
                                end
                            end
                            break;
                        end
                    end
                end
            end
            CMD_READ: begin
                rd = 1'b1;
                rv = (it.cell_index < TAPE_CELLS) ? tape[it.cell_index] : BLANK_SYMBOL;
            end
            default: ;
        endcase
        r.machine_state = mstate;
        r.head_position = head[6:0];
        r.symbol_out = rd ? rv : tape[head];
        r.accepted = 1'b0;
        for (int i = 0; i < n_finals; i++) if (finals[i] == mstate) r.accepted = 1'b1;
        r.has_final_states = (n_finals > 0);
        return r;
    endfunction

    initial begin
        clear_machine();
        o_errors = 0;
        o_results = 0;
        o_steps_ok = 0;
        o_faults = 0;
    end

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item pred;
        if (i_rst_n && i_out_valid && i_out_ready) begin
            o_results++;
            if (expected_results.size() == 0) begin
                o_errors++;
                if (o_errors <= 10) $display("unexpected result %p", i_out_data);
            end else begin
                want = expected_results.pop_front();
                if (want.status == ST_FAULT) o_faults++;
                if (i_out_data !== want) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("mismatch: expected %p actual %p", want, i_out_data);
                end
            end
        end
        if (i_rst_n && i_in_valid && i_in_ready) begin
            pred = machine_step(i_in_data);
            if (i_in_data.cmd == CMD_STEP && pred.status == ST_OK) o_steps_ok++;
            expected_results.push_back(pred);
        end
    end
endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps
// stimulus and verdict for the turing machine step engine
// depends on tmse_pkg, turing_machine_step_engine and tb_checker
module tb_top;
    import tmse_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    t_in_item  in_data;
    logic      out_valid;
    logic      out_ready;
    t_out_item out_data;
    int        errors;
    int        pending;
    int        results;
    int        steps_ok;
    int        faults;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        hold_cycles;

    turing_machine_step_engine u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_in_data(in_data), .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_out_data(out_data)
    );

    tb_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_in_valid(in_valid), .i_in_ready(in_ready),
        .i_in_data(in_data), .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_out_data(out_data), .o_errors(errors), .o_pending(pending),
        .o_results(results), .o_steps_ok(steps_ok), .o_faults(faults)
    );

    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // receiver: random stalls, plus a long hold-off when requested
    always @(posedge clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic send_item(t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    function automatic t_in_item blank_item(logic [2:0] c);
        t_in_item it;
        it = t_in_item'($bits(t_in_item)'({$urandom, $urandom}));
        it.cmd = c;
        return it;
    endfunction

    task automatic put_rule(logic [7:0] f, logic [7:0] r, logic [7:0] n, logic [7:0] w,
                            logic [1:0] m);
        t_in_item it;
        it = blank_item(CMD_ADD_RULE);
        it.rule_from_state = f;
        it.rule_read_symbol = r;
        it.rule_next_state = n;
        it.rule_write_symbol = w;
        it.rule_move = m;
        send_item(it);
    endtask

    task automatic put_cell(int idx, logic [7:0] s);
        t_in_item it;
        it = blank_item(CMD_WRITE);
        it.cell_index = idx[6:0];
        it.cell_symbol = s;
        send_item(it);
    endtask

    // a small machine over a few states and symbols, then mostly steps mixed with other items
    task automatic random_program();
        int nst;
        int nsy;
        int nr;
        int nsteps;
        t_in_item it;
        nst = $urandom_range(4, 1);
        nsy = $urandom_range(3, 1);
        send_item(blank_item(CMD_CLEAR));
        nr = $urandom_range(10, 2);
        for (int i = 0; i < nr; i++)
            put_rule(8'($urandom_range(nst - 1)), ($urandom_range(3) == 0) ? BLANK_SYMBOL
                     : 8'($urandom_range(nsy - 1)), 8'($urandom_range(nst - 1)),
                     ($urandom_range(3) == 0) ? BLANK_SYMBOL : 8'($urandom_range(nsy - 1)),
                     2'($urandom_range(3)));
        for (int i = 0; i < $urandom_range(2); i++) begin
            it = blank_item(CMD_ADD_FINAL);
            it.accept_state = 8'($urandom_range(nst - 1));
            send_item(it);
        end
        for (int i = 0; i < $urandom_range(4); i++)
            put_cell($urandom_range(8), 8'($urandom_range(nsy - 1)));
        nsteps = $urandom_range(12, 3);
        for (int i = 0; i < nsteps; i++) begin
            if ($urandom_range(9) == 0) begin
                it = blank_item(3'($urandom_range(7)));
                if (it.cmd == CMD_CLEAR) it.cmd = CMD_READ;
            end else begin
                it = blank_item(CMD_STEP);
            end
            send_item(it);
        end
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        in_valid <= 1'b0;
        while (pending != 0 && guard < 100000) begin
            @(posedge clk);
            guard++;
        end
        repeat (300) @(posedge clk);
    endtask

    initial begin
        t_in_item it;
        in_valid = 1'b0;
        in_data = '0;
        out_ready = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 36;
        recv_idle_pct = 47;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: a read, a halt, a short walk right, unknown commands, the left end, then the right end
        put_rule(8'd0, BLANK_SYMBOL, 8'd0, 8'hff, MOVE_RIGHT);
        put_rule(8'd0, 8'hff, 8'd255, 8'd0, 2'd3);
        it = blank_item(CMD_ADD_FINAL);
        it.accept_state = 8'd0;
        send_item(it);
        put_cell(0, 8'h00);
        put_cell(127, 8'hff);
        it = blank_item(CMD_READ);
        it.cell_index = 7'd127;
        send_item(it);
        send_item(blank_item(CMD_STEP));
        put_cell(0, BLANK_SYMBOL);
        for (int i = 0; i < 3; i++) send_item(blank_item(CMD_STEP));
        send_item(blank_item(3'd6));
        send_item(blank_item(3'd7));
        send_item(blank_item(CMD_CLEAR));
        put_rule(8'd0, BLANK_SYMBOL, 8'd1, 8'd0, MOVE_LEFT);
        send_item(blank_item(CMD_STEP));
        send_item(blank_item(CMD_STEP));
        send_item(blank_item(CMD_CLEAR));
        put_rule(8'd0, BLANK_SYMBOL, 8'd0, BLANK_SYMBOL, MOVE_RIGHT);
        for (int i = 0; i < 128; i++) send_item(blank_item(CMD_STEP));
        // fill rule table and final list past full
        send_item(blank_item(CMD_CLEAR));
        for (int i = 0; i <= MAX_RULES; i++)
            put_rule(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 2'($urandom));
        for (int i = 0; i <= MAX_FINALS; i++) send_item(blank_item(CMD_ADD_FINAL));
        send_item(blank_item(CMD_STEP));
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 36 : (phase == 1) ? 47 : 0;
            recv_idle_pct = (phase == 0) ? 47 : (phase == 1) ? 36 : 0;
            if (phase == 1) hold_cycles <= 2000;
            for (int p = 0; p < 14; p++) random_program();
            drain();
        end

        $display("ran directed edge cases and random machine programs: %0d results, %0d moves,",
                 results, steps_ok);
        $display("%0d tape faults; %0d mismatches", faults, errors);
        if (errors == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+sv
sv/tmse_pkg.sv
sv/tmse_ctrl.sv
sv/tmse_dp.sv
sv/turing_machine_step_engine.sv
sv/tmse_checker.sv
tb/tb_checker.sv
tb/tb_top.sv
